// ===== rtl/aids_pkg.sv =====
package aids_pkg;

   localparam int OP_W     = 3;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STAT_W   = 2;
   localparam int FOUND_W  = 4;
   localparam int COUNT_W  = 5;
   localparam int UPC_W    = 5;

   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

   // index register operations
   localparam logic [2:0] IDX_HOLD = 3'd0;
   localparam logic [2:0] IDX_CNT  = 3'd1;
   localparam logic [2:0] IDX_POS  = 3'd2;
   localparam logic [2:0] IDX_ZERO = 3'd3;
   localparam logic [2:0] IDX_INC  = 3'd4;
   localparam logic [2:0] IDX_DEC  = 3'd5;

   // read address select
   localparam logic [1:0] RA_IDX = 2'd0;
   localparam logic [1:0] RA_DEC = 2'd1;
   localparam logic [1:0] RA_INC = 2'd2;

   // write data select
   localparam logic WD_RDATA = 1'b0;
   localparam logic WD_VALUE = 1'b1;

   // count operations
   localparam logic [1:0] CNT_HOLD = 2'd0;
   localparam logic [1:0] CNT_CLR  = 2'd1;
   localparam logic [1:0] CNT_INC  = 2'd2;
   localparam logic [1:0] CNT_DEC  = 2'd3;

   // jump conditions
   localparam logic [2:0] CND_NEXT       = 3'd0;
   localparam logic [2:0] CND_ALWAYS     = 3'd1;
   localparam logic [2:0] CND_IDX_EQ_POS = 3'd2;
   localparam logic [2:0] CND_LAST       = 3'd3;
   localparam logic [2:0] CND_IDX_EQ_CNT = 3'd4;
   localparam logic [2:0] CND_HIT        = 3'd5;

   // microprogram addresses
   localparam logic [UPC_W-1:0] U_CLR       = 5'd0;
   localparam logic [UPC_W-1:0] U_NOP       = 5'd1;
   localparam logic [UPC_W-1:0] U_FULL      = 5'd2;
   localparam logic [UPC_W-1:0] U_BAD       = 5'd3;
   localparam logic [UPC_W-1:0] U_INS_INIT  = 5'd4;
   localparam logic [UPC_W-1:0] U_INS_LOOP  = 5'd5;
   localparam logic [UPC_W-1:0] U_INS_MOVE  = 5'd6;
   localparam logic [UPC_W-1:0] U_INS_PUT   = 5'd7;
   localparam logic [UPC_W-1:0] U_DEL_INIT  = 5'd8;
   localparam logic [UPC_W-1:0] U_DEL_LOOP  = 5'd9;
   localparam logic [UPC_W-1:0] U_DEL_MOVE  = 5'd10;
   localparam logic [UPC_W-1:0] U_DEL_END   = 5'd11;
   localparam logic [UPC_W-1:0] U_SRCH_INIT = 5'd12;
   localparam logic [UPC_W-1:0] U_SRCH_LOOP = 5'd13;
   localparam logic [UPC_W-1:0] U_SRCH_TEST = 5'd14;
   localparam logic [UPC_W-1:0] U_SRCH_INC  = 5'd15;
   localparam logic [UPC_W-1:0] U_SRCH_MISS = 5'd16;
   localparam logic [UPC_W-1:0] U_SRCH_HIT  = 5'd17;
   localparam logic [UPC_W-1:0] U_RD_INIT   = 5'd18;
   localparam logic [UPC_W-1:0] U_RD_ADDR   = 5'd19;
   localparam logic [UPC_W-1:0] U_RD_OUT    = 5'd20;

   typedef struct packed {
      logic [2:0]        idx_op;
      logic              rd_en;
      logic [1:0]        ra_sel;
      logic              wr_en;
      logic              wd_sel;
      logic [1:0]        cnt_op;
      logic [2:0]        cond;
      logic [UPC_W-1:0]  target;
      logic              fin;
      logic [STAT_W-1:0] rsp_status;
      logic              rsp_found;
      logic              rsp_read;
   } ctrl_type;

   typedef struct packed {
      logic full;
      logic ins_bad;
      logic pos_bad;
      logic idx_eq_pos;
      logic idx_last;
      logic idx_eq_cnt;
      logic hit;
   } flags_type;

   function automatic ctrl_type mk(
      input logic [2:0]        idx_op,
      input logic              rd_en,
      input logic [1:0]        ra_sel,
      input logic              wr_en,
      input logic              wd_sel,
      input logic [1:0]        cnt_op,
      input logic [2:0]        cond,
      input logic [UPC_W-1:0]  target,
      input logic              fin,
      input logic [STAT_W-1:0] rsp_status,
      input logic              rsp_found,
      input logic              rsp_read
   );
      ctrl_type c;
      c.idx_op     = idx_op;
      c.rd_en      = rd_en;
      c.ra_sel     = ra_sel;
      c.wr_en      = wr_en;
      c.wd_sel     = wd_sel;
      c.cnt_op     = cnt_op;
      c.cond       = cond;
      c.target     = target;
      c.fin        = fin;
      c.rsp_status = rsp_status;
      c.rsp_found  = rsp_found;
      c.rsp_read   = rsp_read;
      return c;
   endfunction

   // control store: one word per step
   function automatic ctrl_type ucode_rom(input logic [UPC_W-1:0] upc);
      ctrl_type c;
      case (upc)
         U_CLR: c = mk(IDX_HOLD, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_CLR, CND_NEXT,
                       U_CLR, 1'b1, ST_OK, 1'b0, 1'b0);
         U_NOP: c = mk(IDX_HOLD, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD, CND_NEXT,
                       U_CLR, 1'b1, ST_OK, 1'b0, 1'b0);
         U_FULL: c = mk(IDX_HOLD, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD, CND_NEXT,
                        U_CLR, 1'b1, ST_FULL, 1'b0, 1'b0);
         U_BAD: c = mk(IDX_HOLD, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD, CND_NEXT,
                       U_CLR, 1'b1, ST_BADPOS, 1'b0, 1'b0);
         U_INS_INIT: c = mk(IDX_CNT, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD, CND_NEXT,
                            U_CLR, 1'b0, ST_OK, 1'b0, 1'b0);
         U_INS_LOOP: c = mk(IDX_HOLD, 1'b1, RA_DEC, 1'b0, WD_RDATA, CNT_HOLD,
                            CND_IDX_EQ_POS, U_INS_PUT, 1'b0, ST_OK, 1'b0, 1'b0);
         U_INS_MOVE: c = mk(IDX_DEC, 1'b0, RA_IDX, 1'b1, WD_RDATA, CNT_HOLD, CND_ALWAYS,
                            U_INS_LOOP, 1'b0, ST_OK, 1'b0, 1'b0);
         U_INS_PUT: c = mk(IDX_HOLD, 1'b0, RA_IDX, 1'b1, WD_VALUE, CNT_INC, CND_NEXT,
                           U_CLR, 1'b1, ST_OK, 1'b0, 1'b0);
         U_DEL_INIT: c = mk(IDX_POS, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD, CND_NEXT,
                            U_CLR, 1'b0, ST_OK, 1'b0, 1'b0);
         U_DEL_LOOP: c = mk(IDX_HOLD, 1'b1, RA_INC, 1'b0, WD_RDATA, CNT_HOLD, CND_LAST,
                            U_DEL_END, 1'b0, ST_OK, 1'b0, 1'b0);
         U_DEL_MOVE: c = mk(IDX_INC, 1'b0, RA_IDX, 1'b1, WD_RDATA, CNT_HOLD, CND_ALWAYS,
                            U_DEL_LOOP, 1'b0, ST_OK, 1'b0, 1'b0);
         U_DEL_END: c = mk(IDX_HOLD, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_DEC, CND_NEXT,
                           U_CLR, 1'b1, ST_OK, 1'b0, 1'b0);
         U_SRCH_INIT: c = mk(IDX_ZERO, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD, CND_NEXT,
                             U_CLR, 1'b0, ST_OK, 1'b0, 1'b0);
         U_SRCH_LOOP: c = mk(IDX_HOLD, 1'b1, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD,
                             CND_IDX_EQ_CNT, U_SRCH_MISS, 1'b0, ST_OK, 1'b0, 1'b0);
         U_SRCH_TEST: c = mk(IDX_HOLD, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD, CND_HIT,
                             U_SRCH_HIT, 1'b0, ST_OK, 1'b0, 1'b0);
         U_SRCH_INC: c = mk(IDX_INC, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD, CND_ALWAYS,
                            U_SRCH_LOOP, 1'b0, ST_OK, 1'b0, 1'b0);
         U_SRCH_MISS: c = mk(IDX_HOLD, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD, CND_NEXT,
                             U_CLR, 1'b1, ST_NOTFOUND, 1'b0, 1'b0);
         U_SRCH_HIT: c = mk(IDX_HOLD, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD, CND_NEXT,
                            U_CLR, 1'b1, ST_OK, 1'b1, 1'b0);
         U_RD_INIT: c = mk(IDX_POS, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD, CND_NEXT,
                           U_CLR, 1'b0, ST_OK, 1'b0, 1'b0);
         U_RD_ADDR: c = mk(IDX_HOLD, 1'b1, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD, CND_NEXT,
                           U_CLR, 1'b0, ST_OK, 1'b0, 1'b0);
         U_RD_OUT: c = mk(IDX_HOLD, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD, CND_NEXT,
                          U_CLR, 1'b1, ST_OK, 1'b0, 1'b1);
         default: c = mk(IDX_HOLD, 1'b0, RA_IDX, 1'b0, WD_RDATA, CNT_HOLD, CND_NEXT,
                         U_CLR, 1'b1, ST_OK, 1'b0, 1'b0);
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/aids_seq.sv =====
module aids_seq
   import aids_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [OP_W-1:0] opcode,
   input  flags_type       flags,
   output logic            busy,
   output ctrl_type        ctrl
);

   logic             busy_ff, busy_in;
   logic [UPC_W-1:0] upc_ff, upc_in;
   logic [UPC_W-1:0] entry;
   ctrl_type         word;
   logic             take;

   // dispatch: pick the routine and apply the argument checks
   always_comb begin
      case (opcode)
         OP_CLEAR:  entry = U_CLR;
         OP_INSERT: entry = flags.full ? U_FULL : (flags.ins_bad ? U_BAD : U_INS_INIT);
         OP_DELETE: entry = flags.pos_bad ? U_BAD : U_DEL_INIT;
         OP_SEARCH: entry = U_SRCH_INIT;
         OP_READ:   entry = flags.pos_bad ? U_BAD : U_RD_INIT;
         default:   entry = U_NOP;
      endcase
   end

   assign word = ucode_rom(upc_ff);

   always_comb begin
      case (word.cond)
         CND_NEXT:       take = 1'b0;
         CND_ALWAYS:     take = 1'b1;
         CND_IDX_EQ_POS: take = flags.idx_eq_pos;
         CND_LAST:       take = flags.idx_last;
         CND_IDX_EQ_CNT: take = flags.idx_eq_cnt;
         CND_HIT:        take = flags.hit;
         default:        take = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      upc_in  = upc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            upc_in  = entry;
         end
      end else if (word.fin) begin
         busy_in = 1'b0;
      end else begin
         upc_in = take ? word.target : upc_ff + UPC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= U_CLR;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

   assign busy = busy_ff;
   assign ctrl = busy_ff ? word : '0;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("accepted beat did not start the sequencer");

   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && word.fin) |=> !busy_ff)
      else $error("sequencer still busy after final step");

endmodule

// ===== rtl/aids_dpath.sv =====
module aids_dpath
   import aids_pkg::*;
#(
   parameter int CAPACITY = 16
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic signed [DATA_W-1:0] req_key,
   input  ctrl_type                 ctrl,
   output flags_type                flags,
   output logic                     rsp_strobe,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [FOUND_W-1:0]       rsp_found_index,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [COUNT_W-1:0]       rsp_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic signed [DATA_W-1:0] mem [CAPACITY];

   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [POS_W-1:0]         pos_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] key_ff;
   logic signed [DATA_W-1:0] rdata_ff;
   logic [CNT_W-1:0]         raddr;
   logic signed [DATA_W-1:0] wdata;
   logic [CMP_W-1:0]         pos_ext, req_pos_ext, cnt_ext, idx_ext;
   logic [CNT_W:0]           idx_plus;

   logic                     strobe_ff;
   logic [STAT_W-1:0]        status_ff;
   logic [FOUND_W-1:0]       found_ff;
   logic signed [DATA_W-1:0] read_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic [CMP_W-1:0]         idx_out_ext, cnt_out_ext;

   assign pos_ext     = CMP_W'(pos_ff);
   assign req_pos_ext = CMP_W'(req_position);
   assign cnt_ext     = CMP_W'(cnt_ff);
   assign idx_ext     = CMP_W'(idx_ff);
   assign idx_plus    = {1'b0, idx_ff} + (CNT_W + 1)'(1);

   always_comb begin
      flags.full       = (cnt_ff >= CNT_W'(CAPACITY));
      flags.ins_bad    = (req_pos_ext > cnt_ext);
      flags.pos_bad    = (req_pos_ext >= cnt_ext);
      flags.idx_eq_pos = (idx_ext == pos_ext);
      flags.idx_last   = (idx_plus >= {1'b0, cnt_ff});
      flags.idx_eq_cnt = (idx_ff == cnt_ff);
      flags.hit        = (rdata_ff == key_ff);
   end

   always_comb begin
      case (ctrl.idx_op)
         IDX_CNT:  idx_in = cnt_ff;
         IDX_POS:  idx_in = pos_ext[CNT_W-1:0];
         IDX_ZERO: idx_in = '0;
         IDX_INC:  idx_in = idx_ff + CNT_W'(1);
         IDX_DEC:  idx_in = idx_ff - CNT_W'(1);
         default:  idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (ctrl.cnt_op)
         CNT_CLR: cnt_in = '0;
         CNT_INC: cnt_in = cnt_ff + CNT_W'(1);
         CNT_DEC: cnt_in = cnt_ff - CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_comb begin
      case (ctrl.ra_sel)
         RA_DEC:  raddr = idx_ff - CNT_W'(1);
         RA_INC:  raddr = idx_ff + CNT_W'(1);
         default: raddr = idx_ff;
      endcase
   end

   assign wdata = (ctrl.wd_sel == WD_VALUE) ? value_ff : rdata_ff;

   // entry store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[idx_ff[IDX_W-1:0]] <= wdata;
      end
      if (ctrl.rd_en) begin
         rdata_ff <= mem[raddr[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pos_ff   <= req_position;
         value_ff <= req_value;
         key_ff   <= req_key;
      end
      idx_ff <= idx_in;
   end

   assign idx_out_ext = CMP_W'(idx_ff);
   assign cnt_out_ext = CMP_W'(cnt_in);

   always_ff @(posedge clock) begin
      if (ctrl.fin) begin
         status_ff <= ctrl.rsp_status;
         found_ff  <= ctrl.rsp_found ? idx_out_ext[FOUND_W-1:0] : '0;
         read_ff   <= ctrl.rsp_read ? rdata_ff : '0;
         count_ff  <= cnt_out_ext[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         strobe_ff <= ctrl.fin;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_index = found_ff;
   assign rsp_read_value  = read_ff;
   assign rsp_count       = count_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (ctrl.fin && ctrl.rsp_status == ST_FULL) |-> (cnt_ff == CNT_W'(CAPACITY)))
      else $error("full status with room left");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_en |-> (idx_ff < cnt_ff || (idx_ff == cnt_ff && cnt_ff < CNT_W'(CAPACITY))))
      else $error("write outside the filled region");

endmodule

// ===== rtl/array_insert_delete_search_top.sv =====
// positional array store: clear, insert, delete, linear search and read
// command side: drive req_opcode, req_position, req_value and req_key with start
// high; the beat is taken at a clock edge where start is high and busy is low.
// busy stays high until the operation finishes.
// result side: one beat per command, shown for one cycle with rsp_strobe high,
// carrying status, found index, read value and the count after the command.
// the receiver cannot stall; it must take the beat in that cycle.
// steps from the accepting edge to the strobe: clear, unused opcodes and
// rejected commands finish in their only step; insert and delete shift each
// entry with a read step and then a write step; search reads, tests and
// advances per entry; read loads the position, reads the entry and returns it.
// the entry store read is registered, so each shift reads an entry into a
// register and then writes it back one place over.
// a new command may be started in the cycle the strobe is high.
// reset empties the store (count zero) and drops busy; entry contents are not
// cleared and never reach a reply until written.
module array_insert_delete_search_top
   import aids_pkg::*;
#(
   parameter int CAPACITY = 16
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [OP_W-1:0]           req_opcode,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic signed [DATA_W-1:0]  req_key,
   output logic                      rsp_strobe,
   output logic [STAT_W-1:0]         rsp_status,
   output logic [FOUND_W-1:0]        rsp_found_index,
   output logic signed [DATA_W-1:0]  rsp_read_value,
   output logic [COUNT_W-1:0]        rsp_count
);

   ctrl_type  ctrl;
   flags_type flags;
   logic      load;

   assign load = start && !busy;

   aids_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_opcode),
      .flags  (flags),
      .busy   (busy),
      .ctrl   (ctrl)
   );

   aids_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .req_position    (req_position),
      .req_value       (req_value),
      .req_key         (req_key),
      .ctrl            (ctrl),
      .flags           (flags),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_read_value  (rsp_read_value),
      .rsp_count       (rsp_count)
   );

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while command still running");

endmodule

// ===== test/array_insert_delete_search_top_tb.sv =====
`timescale 1ns / 1ps

module array_insert_delete_search_top_tb
   import aids_pkg::*;
();

   localparam int CAP         = 16;
   localparam int SIDX_W      = $clog2(CAP);
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 3 * CAP + 8;
   localparam int RANDOM_PER_PHASE = 250;

   // opcodes the block leaves without effect
   localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

   typedef struct {
      logic [OP_W-1:0]          opcode;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] key;
   } store_cmd_type;

   typedef struct {
      logic [STAT_W-1:0]        status;
      logic [FOUND_W-1:0]       found_index;
      logic signed [DATA_W-1:0] read_value;
      logic [COUNT_W-1:0]       count;
   } store_reply_type;

   typedef struct {
      store_cmd_type   cmd;
      int              reps;
      bit              typed;
      store_reply_type want;
   } directed_row_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [OP_W-1:0]          req_opcode;
   logic [POS_W-1:0]         req_position;
   logic signed [DATA_W-1:0] req_value;
   logic signed [DATA_W-1:0] req_key;
   logic                     rsp_strobe;
   logic [STAT_W-1:0]        rsp_status;
   logic [FOUND_W-1:0]       rsp_found_index;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [COUNT_W-1:0]       rsp_count;

   // shadow copy of the store contents
   logic signed [DATA_W-1:0] shadow_entries [CAP];
   int                       shadow_count;

   store_reply_type  replies_due [$];
   directed_row_type directed_rows [$];
   int               cmds_sent;
   int               directed_sent;
   int               replies_checked;
   int               mismatch_count;
   int               status_tally [4];
   int               quiet_cycles;
   bit               grow;

   array_insert_delete_search_top #(.CAPACITY(CAP)) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_value       (req_value),
      .req_key         (req_key),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_read_value  (rsp_read_value),
      .rsp_count       (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // applies one command to the shadow store and returns the reply it earns
   function automatic store_reply_type apply_store_op(store_cmd_type c);
      store_reply_type r;
      bit              hit;
      r.status      = ST_OK;
      r.found_index = '0;
      r.read_value  = '0;
      hit           = 1'b0;
      case (c.opcode)
         OP_CLEAR: begin
            shadow_count = 0;
         end
         OP_INSERT: begin
            if (shadow_count >= CAP) begin
               r.status = ST_FULL;
            end else if (c.position > shadow_count) begin
               r.status = ST_BADPOS;
            end else begin
               for (int i = shadow_count; i > c.position; i--)
                  shadow_entries[SIDX_W'(i)] = shadow_entries[SIDX_W'(i-1)];
               shadow_entries[c.position[SIDX_W-1:0]] = c.value;
               shadow_count++;
            end
         end
         OP_DELETE: begin
            if (c.position >= shadow_count) begin
               r.status = ST_BADPOS;
            end else begin
               for (int i = c.position; i + 1 < shadow_count; i++)
                  shadow_entries[SIDX_W'(i)] = shadow_entries[SIDX_W'(i+1)];
               shadow_count--;
            end
         end
         OP_SEARCH: begin
            r.status = ST_NOTFOUND;
            for (int i = 0; i < shadow_count; i++) begin
               if (!hit && shadow_entries[SIDX_W'(i)] == c.key) begin
                  hit           = 1'b1;
                  r.status      = ST_OK;
                  r.found_index = i[FOUND_W-1:0];
               end
            end
         end
         OP_READ: begin
            if (c.position >= shadow_count)
               r.status = ST_BADPOS;
            else
               r.read_value = shadow_entries[c.position[SIDX_W-1:0]];
         end
         default: ;
      endcase
      r.count = shadow_count[COUNT_W-1:0];
      return r;
   endfunction

   function automatic void add_row(logic [OP_W-1:0] op, int pos, int val, int key,
                                   int reps, int typed, logic [STAT_W-1:0] st, int fi,
                                   int rd, int cnt);
      directed_row_type row;
      row.cmd.opcode        = op;
      row.cmd.position      = POS_W'(pos);
      row.cmd.value         = val;
      row.cmd.key           = key;
      row.reps              = reps;
      row.typed             = (typed != 0);
      row.want.status       = st;
      row.want.found_index  = FOUND_W'(fi);
      row.want.read_value   = rd;
      row.want.count        = COUNT_W'(cnt);
      directed_rows.push_back(row);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_word();
      int roll;
      roll = $urandom_range(99);
      if (roll < 20)
         return $urandom_range(3);
      if (roll < 30) begin
         case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            default: return 32'sd0;
         endcase
      end
      return $urandom;
   endfunction

   // mostly well-formed commands; the fill level swings between empty and full
   function automatic store_cmd_type make_random_cmd();
      store_cmd_type c;
      int roll;
      roll = $urandom_range(99);
      if (roll < (grow ? 45 : 10))
         c.opcode = OP_INSERT;
      else if (roll < (grow ? 55 : 50))
         c.opcode = OP_DELETE;
      else if (roll < (grow ? 75 : 70))
         c.opcode = OP_SEARCH;
      else if (roll < 94)
         c.opcode = OP_READ;
      else if (roll < 96)
         c.opcode = OP_CLEAR;
      else
         c.opcode = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      if ($urandom_range(99) < 88) begin
         if (c.opcode == OP_INSERT)
            c.position = POS_W'($urandom_range(shadow_count));
         else
            c.position = (shadow_count > 0) ? POS_W'($urandom_range(shadow_count - 1))
                                            : '0;
      end else begin
         c.position = POS_W'($urandom_range(31));
      end
      c.value = pick_word();
      if (shadow_count > 0 && $urandom_range(99) < 60)
         c.key = shadow_entries[SIDX_W'($urandom_range(shadow_count - 1))];
      else
         c.key = pick_word();
      return c;
   endfunction

   task automatic send_cmd(store_cmd_type c, bit typed, store_reply_type want);
      store_reply_type r;
      @(negedge clock);
      start        = 1'b1;
      req_opcode   = c.opcode;
      req_position = c.position;
      req_value    = c.value;
      req_key      = c.key;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = apply_store_op(c);
      if (typed)
         r = want;
      replies_due.push_back(r);
      cmds_sent++;
   endtask

   task automatic idle_gap(int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   always @(posedge clock) begin
      store_reply_type exp;
      if (!reset && rsp_strobe) begin
         status_tally[rsp_status]++;
         if (replies_due.size() == 0) begin
            $error("reply beat with nothing outstanding: status %0d count %0d",
                   rsp_status, rsp_count);
            mismatch_count++;
         end else begin
            exp = replies_due.pop_front();
            replies_checked++;
            if (rsp_status !== exp.status) begin
               $error("status: expected %0d, got %0d", exp.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_found_index !== exp.found_index) begin
               $error("found_index: expected %0d, got %0d", exp.found_index,
                      rsp_found_index);
               mismatch_count++;
            end
            if (rsp_read_value !== exp.read_value) begin
               $error("read_value: expected %0d, got %0d", exp.read_value,
                      rsp_read_value);
               mismatch_count++;
            end
            if (rsp_count !== exp.count) begin
               $error("count: expected %0d, got %0d", exp.count, rsp_count);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat taken on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      store_reply_type none;
      int idle_pct [3];
      start           = 1'b0;
      req_opcode      = OP_CLEAR;
      req_position    = '0;
      req_value       = '0;
      req_key         = '0;
      reset           = 1'b1;
      shadow_count    = 0;
      cmds_sent       = 0;
      replies_checked = 0;
      mismatch_count  = 0;
      quiet_cycles    = 0;
      grow            = 1'b1;
      status_tally    = '{0, 0, 0, 0};
      none            = '{ST_OK, '0, '0, '0};
      idle_pct        = '{0, 68, 27};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty store: every read or delete position is out of range; then two inserts and lookups
      add_row(OP_READ,   0, 0, 0, 1, 1, ST_BADPOS,   0, 0, 0);
      add_row(OP_DELETE, 0, 0, 0, 1, 1, ST_BADPOS,   0, 0, 0);
      add_row(OP_SEARCH, 0, 0, 0, 1, 1, ST_NOTFOUND, 0, 0, 0);
      add_row(OP_INSERT, 1, 0, 0, 1, 1, ST_BADPOS,   0, 0, 0);
      add_row(OP_INSERT, 0, 32'sh8000_0000, 0, 1, 1, ST_OK, 0, 0, 1);
      add_row(OP_INSERT, 1, 32'sh7fff_ffff, 0, 1, 1, ST_OK, 0, 0, 2);
      add_row(OP_READ,   0, 0, 0, 1, 1, ST_OK, 0, 32'sh8000_0000, 2);
      add_row(OP_READ,   1, 0, 0, 1, 1, ST_OK, 0, 32'sh7fff_ffff, 2);
      add_row(OP_SEARCH, 0, 0, 32'sh7fff_ffff, 1, 1, ST_OK, 1, 0, 2);
      // duplicates at the front and the back, search takes the lowest
      add_row(OP_INSERT, 0, -1, 0, 1, 0, ST_OK, 0, 0, 0);
      add_row(OP_INSERT, 3, -1, 0, 1, 0, ST_OK, 0, 0, 0);
      add_row(OP_SEARCH, 0, 0, -1, 1, 0, ST_OK, 0, 0, 0);
      add_row(OP_DELETE, 0, 0, 0, 1, 0, ST_OK, 0, 0, 0);
      add_row(OP_SPARE_LO,  31, -1, -1, 1, 0, ST_OK, 0, 0, 0);
      add_row(OP_SPARE_MID, 0, 0, 0, 1, 0, ST_OK, 0, 0, 0);
      add_row(OP_SPARE_HI,  31, -1, -1, 1, 0, ST_OK, 0, 0, 0);
      add_row(OP_INSERT, 31, 5, 0, 1, 0, ST_OK, 0, 0, 0);
      add_row(OP_READ,   31, 0, 0, 1, 0, ST_OK, 0, 0, 0);
      // fill up to one below capacity, then append the last slot
      add_row(OP_INSERT, 1, 0, 0, 12, 0, ST_OK, 0, 0, 0);
      add_row(OP_INSERT, 15, 32'sh5a5a_5a5a, 0, 1, 1, ST_OK, 0, 0, 16);
      add_row(OP_INSERT, 0, 9, 0, 1, 1, ST_FULL, 0, 0, 16);
      add_row(OP_SEARCH, 0, 0, 32'sh5a5a_5a5a, 1, 1, ST_OK, 15, 0, 16);
      add_row(OP_READ,   16, 0, 0, 1, 1, ST_BADPOS, 0, 0, 16);
      add_row(OP_DELETE, 15, 0, 0, 1, 0, ST_OK, 0, 0, 0);
      add_row(OP_DELETE, 0, 0, 0, 1, 0, ST_OK, 0, 0, 0);
      add_row(OP_SEARCH, 0, 0, 12345, 1, 0, ST_OK, 0, 0, 0);
      add_row(OP_CLEAR,  0, 0, 0, 1, 1, ST_OK, 0, 0, 0);

      foreach (directed_rows[n])
         repeat (directed_rows[n].reps)
            send_cmd(directed_rows[n].cmd, directed_rows[n].typed, directed_rows[n].want);
      directed_sent = cmds_sent;

      foreach (idle_pct[ph]) begin
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            if (idle_pct[ph] > 0 && $urandom_range(99) < idle_pct[ph])
               idle_gap($urandom_range(1, 6));
            send_cmd(make_random_cmd(), 1'b0, none);
            if (shadow_count == CAP)
               grow = 1'b0;
            else if (shadow_count == 0)
               grow = 1'b1;
            else if ($urandom_range(99) < 3)
               grow = !grow;
         end
      end

      @(negedge clock);
      start = 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d commands driven (%0d directed), %0d reply beats checked",
               cmds_sent, directed_sent, replies_checked);
      $display("statuses seen: ok %0d, full %0d, bad position %0d, not found %0d",
               status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_BADPOS],
               status_tally[ST_NOTFOUND]);
      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
